### rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types, constants and helper functions for the MurmurHash3 x64 128
// engine: mixing constants, sequencer states and multiplier request/response.
// ----------------------------------------------------------------------------
package mm3_pkg;

    localparam logic [63:0] C1   = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] C2   = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] ADD1 = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] ADD2 = 64'h0000_0000_3849_5ab5;
    localparam logic [63:0] F1   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] F2   = 64'hc4ce_b9fe_1a85_ec53;

    localparam logic [4:0] FULL_BYTES = 5'd16;
    localparam logic [4:0] HALF_BYTES = 5'd8;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_K1_C1,
        ST_K1_C2,
        ST_L1_MIX,
        ST_L1_MUL5,
        ST_K2_C2,
        ST_K2_C1,
        ST_L2_MIX,
        ST_L2_MUL5,
        ST_LEN,
        ST_FOLD,
        ST_CROSS,
        ST_FM1_A,
        ST_FM1_B,
        ST_FM2_A,
        ST_FM2_B,
        ST_SUM1,
        ST_SUM2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } t_mul_rsp;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] xs33(input logic [63:0] x);
        return x ^ (x >> 33);
    endfunction

    // keeps bytes 0..7 of the low word that lie below the count
    function automatic logic [63:0] mask_lo(input logic [4:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (n > 5'(i)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // keeps bytes 8..15 of the high word that lie below the count
    function automatic logic [63:0] mask_hi(input logic [4:0] n);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (n > 5'(i + 8)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

### rtl/mm3_in_if.sv
// ----------------------------------------------------------------------------
// mm3_in_if
// Key block channel: two little-endian words, byte count and last flag.
// ----------------------------------------------------------------------------
interface mm3_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [4:0]  valid_bytes;
    logic        is_last;

    modport source (output valid, block_low, block_high, valid_bytes, is_last, input ready);
    modport sink   (input valid, block_low, block_high, valid_bytes, is_last, output ready);
endinterface

### rtl/mm3_out_if.sv
// ----------------------------------------------------------------------------
// mm3_out_if
// Hash result channel: 128-bit hash as two words and a rejected-block flag.
// ----------------------------------------------------------------------------
interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_low;
    logic [63:0] hash_high;
    logic        bad_block;

    modport source (output valid, hash_low, hash_high, bad_block, input ready);
    modport sink   (input valid, hash_low, hash_high, bad_block, output ready);
endinterface

### rtl/mm3_cfg_if.sv
// ----------------------------------------------------------------------------
// mm3_cfg_if
// Seed register write channel.
// ----------------------------------------------------------------------------
interface mm3_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/mm3_mul64.sv
// ----------------------------------------------------------------------------
// mm3_mul64
// Low 64 bits of a 64x64 product from one shared 32x32 multiplier, adding
// partial products; done is flagged in the cycle after the last step.
// ----------------------------------------------------------------------------
module mm3_mul64 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mm3_pkg::t_mul_req i_req,
    output mm3_pkg::t_mul_rsp o_rsp
);
    import mm3_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] part;
    logic [63:0] term;
    logic [63:0] n_acc;

    always_comb begin
        unique case (r_step)
            2'd0: begin
                mul_a = r_a[31:0];
                mul_b = r_b[31:0];
            end
            2'd1: begin
                mul_a = r_a[31:0];
                mul_b = r_b[63:32];
            end
            default: begin
                mul_a = r_a[63:32];
                mul_b = r_b[31:0];
            end
        endcase
        part  = 64'(mul_a) * 64'(mul_b);
        term  = (r_step == 2'd0) ? part : {part[31:0], 32'h0};
        n_acc = (r_step == 2'd0) ? term : r_acc + term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

### rtl/murmur3_x64_128_hash.sv
// a full non-last block runs the k1/k2 rounds and length update, then goes idle;
//   a last block then runs fold and fmix64, its tail work set by its byte count
// throughput: one block at a time; the 64-bit multiplies run one after another on
//   the shared 32x32 multiplier, which sets the rate (4 for a block, 4 for fmix)
// a rejected block gives its result in the next cycle and leaves the state as is
// reset: synchronous active-low; seed and byte count clear, engine goes idle
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash
// Streaming MurmurHash3 x64 128-bit engine: block rounds, tail mixing,
// length fold and fmix64 finalization under a small sequencer.
// ----------------------------------------------------------------------------
module murmur3_x64_128_hash (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm3_in_if.sink    i_in,
    mm3_out_if.source o_out,
    mm3_cfg_if.sink   i_cfg
);
    import mm3_pkg::*;

    t_state      r_state, n_state;
    logic        r_wait, n_wait;
    logic [31:0] r_seed;
    logic [63:0] r_l1, n_l1;
    logic [63:0] r_l2, n_l2;
    logic [63:0] r_k1, n_k1;
    logic [63:0] r_k2, n_k2;
    logic [63:0] r_len, n_len;
    logic [4:0]  r_n, n_n;
    logic        r_last, n_last;
    logic [63:0] r_hash_low, n_hash_low;
    logic [63:0] r_hash_high, n_hash_high;
    logic        r_bad, n_bad;

    t_mul_req    mul_req;
    t_mul_rsp    mul_rsp;
    logic        accept;
    logic        in_bad;
    logic [63:0] p;

    mm3_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign i_cfg.ready     = 1'b1;
    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = (r_state == ST_OUT);
    assign o_out.hash_low  = r_hash_low;
    assign o_out.hash_high = r_hash_high;
    assign o_out.bad_block = r_bad;

    assign accept = i_in.valid && i_in.ready;
    assign in_bad = (i_in.valid_bytes > FULL_BYTES)
                 || (!i_in.is_last && (i_in.valid_bytes != FULL_BYTES));
    assign p      = mul_rsp.prod;

    // multiplier operands
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = r_k1;
        mul_req.b     = C1;
        unique case (r_state)
            ST_K1_C1: begin
                mul_req.start = !r_wait;
            end
            ST_K1_C2: begin
                mul_req.start = !r_wait;
                mul_req.b     = C2;
            end
            ST_K2_C2: begin
                mul_req.start = !r_wait;
                mul_req.a     = r_k2;
                mul_req.b     = C2;
            end
            ST_K2_C1: begin
                mul_req.start = !r_wait;
                mul_req.a     = r_k2;
            end
            ST_FM1_A: begin
                mul_req.start = !r_wait;
                mul_req.a     = xs33(r_l1);
                mul_req.b     = F1;
            end
            ST_FM1_B: begin
                mul_req.start = !r_wait;
                mul_req.a     = xs33(r_l1);
                mul_req.b     = F2;
            end
            ST_FM2_A: begin
                mul_req.start = !r_wait;
                mul_req.a     = xs33(r_l2);
                mul_req.b     = F1;
            end
            ST_FM2_B: begin
                mul_req.start = !r_wait;
                mul_req.a     = xs33(r_l2);
                mul_req.b     = F2;
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_l1        = r_l1;
        n_l2        = r_l2;
        n_k1        = r_k1;
        n_k2        = r_k2;
        n_len       = r_len;
        n_n         = r_n;
        n_last      = r_last;
        n_hash_low  = r_hash_low;
        n_hash_high = r_hash_high;
        n_bad       = r_bad;

        if (mul_req.start) begin
            n_wait = 1'b1;
        end
        if (mul_rsp.done) begin
            n_wait = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_bad) begin
                        n_hash_low  = 64'h0;
                        n_hash_high = 64'h0;
                        n_bad       = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        if (r_len == 64'h0) begin
                            n_l1 = 64'(r_seed);
                            n_l2 = 64'(r_seed);
                        end
                        n_k1    = i_in.block_low & mask_lo(i_in.valid_bytes);
                        n_k2    = i_in.block_high & mask_hi(i_in.valid_bytes);
                        n_n     = i_in.valid_bytes;
                        n_last  = i_in.is_last;
                        n_state = (i_in.valid_bytes == 5'd0) ? ST_LEN : ST_K1_C1;
                    end
                end
            end
            ST_K1_C1: begin
                if (mul_rsp.done) begin
                    n_k1    = rotl64(p, 31);
                    n_state = ST_K1_C2;
                end
            end
            ST_K1_C2: begin
                if (mul_rsp.done) begin
                    if (r_n == FULL_BYTES) begin
                        n_k1    = p;
                        n_state = ST_L1_MIX;
                    end else begin
                        n_l1    = r_l1 ^ p;
                        n_state = (r_n > HALF_BYTES) ? ST_K2_C2 : ST_LEN;
                    end
                end
            end
            ST_L1_MIX: begin
                n_l1    = rotl64(r_l1 ^ r_k1, 27) + r_l2;
                n_state = ST_L1_MUL5;
            end
            ST_L1_MUL5: begin
                n_l1    = (r_l1 << 2) + r_l1 + ADD1;
                n_state = ST_K2_C2;
            end
            ST_K2_C2: begin
                if (mul_rsp.done) begin
                    n_k2    = rotl64(p, 33);
                    n_state = ST_K2_C1;
                end
            end
            ST_K2_C1: begin
                if (mul_rsp.done) begin
                    if (r_n == FULL_BYTES) begin
                        n_k2    = p;
                        n_state = ST_L2_MIX;
                    end else begin
                        n_l2    = r_l2 ^ p;
                        n_state = ST_LEN;
                    end
                end
            end
            ST_L2_MIX: begin
                n_l2    = rotl64(r_l2 ^ r_k2, 31) + r_l1;
                n_state = ST_L2_MUL5;
            end
            ST_L2_MUL5: begin
                n_l2    = (r_l2 << 2) + r_l2 + ADD2;
                n_state = ST_LEN;
            end
            ST_LEN: begin
                n_len   = r_len + 64'(r_n);
                n_state = r_last ? ST_FOLD : ST_IDLE;
            end
            ST_FOLD: begin
                n_l1    = (r_l1 ^ r_len) + (r_l2 ^ r_len);
                n_l2    = r_l2 ^ r_len;
                n_state = ST_CROSS;
            end
            ST_CROSS: begin
                n_l2    = r_l2 + r_l1;
                n_state = ST_FM1_A;
            end
            ST_FM1_A: begin
                if (mul_rsp.done) begin
                    n_l1    = p;
                    n_state = ST_FM1_B;
                end
            end
            ST_FM1_B: begin
                if (mul_rsp.done) begin
                    n_l1    = xs33(p);
                    n_state = ST_FM2_A;
                end
            end
            ST_FM2_A: begin
                if (mul_rsp.done) begin
                    n_l2    = p;
                    n_state = ST_FM2_B;
                end
            end
            ST_FM2_B: begin
                if (mul_rsp.done) begin
                    n_l2    = xs33(p);
                    n_state = ST_SUM1;
                end
            end
            ST_SUM1: begin
                n_l1    = r_l1 + r_l2;
                n_state = ST_SUM2;
            end
            ST_SUM2: begin
                n_hash_low  = r_l1;
                n_hash_high = r_l2 + r_l1;
                n_bad       = 1'b0;
                n_len       = 64'h0;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_len   <= 64'h0;
            r_seed  <= 32'h0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_len   <= n_len;
            if (i_cfg.valid && i_cfg.ready) begin
                r_seed <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1        <= n_l1;
        r_l2        <= n_l2;
        r_k1        <= n_k1;
        r_k2        <= n_k2;
        r_n         <= n_n;
        r_last      <= n_last;
        r_hash_low  <= n_hash_low;
        r_hash_high <= n_hash_high;
        r_bad       <= n_bad;
    end

endmodule

### rtl/mm3_chk.sv
// ----------------------------------------------------------------------------
// mm3_chk
// Port-level checks for the hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module mm3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_hash_low,
    input logic [63:0] i_hash_high,
    input logic        i_bad_block
);

    // result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_hash_low) && $stable(i_hash_high))
        else $error("stalled result changed");

    // one item in flight
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("item taken while result pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("engine ready right after taking an item");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_block |-> (i_hash_low == 64'h0) && (i_hash_high == 64'h0))
        else $error("rejected block with nonzero hash");

endmodule

bind murmur3_x64_128_hash mm3_chk u_mm3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hash_low  (o_out.hash_low),
    .i_hash_high (o_out.hash_high),
    .i_bad_block (o_out.bad_block)
);
